// ----- sv/pfl_pkg.sv -----
// shared types and constants for the palette file loader
package pfl_pkg;

    // result status codes
    localparam logic [2:0] ST_BYTE     = 3'd0;
    localparam logic [2:0] ST_ARCH     = 3'd1;
    localparam logic [2:0] ST_RAW      = 3'd2;
    localparam logic [2:0] ST_BAD_FMT  = 3'd3;
    localparam logic [2:0] ST_BAD_SIZE = 3'd4;
    localparam logic [2:0] ST_READ     = 3'd5;

    // loaded palette format codes
    localparam logic [1:0] FMT_NONE = 2'd0;
    localparam logic [1:0] FMT_ARCH = 2'd1;
    localparam logic [1:0] FMT_RAW  = 2'd2;

    // file syntax
    localparam logic [7:0] REC_START  = 8'h13;
    localparam logic [7:0] REC_SET    = 8'h10;
    localparam logic [7:0] ALPHA_FULL = 8'hFF;

    // size limits
    localparam int unsigned SIZE_LIMIT = 65536;
    localparam int BYTE_CNT_W   = 17;
    localparam int TRIPLE_CNT_W = 15;
    localparam int COUNT_OUT_W  = 11;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_FINISH = 3'b010,
        S_READ   = 3'b100
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic byte_step;
        logic finish;
        logic read_issue;
        logic read_done;
    } t_ctl_cmd;

endpackage

// ----- sv/pfl_ram.sv -----
// generic single-write, single-read memory with registered read data
module pfl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/pfl_ctrl.sv -----
// controller state machine: sequences byte steps, load decision and reads
module pfl_ctrl
    import pfl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_mode,
    input  logic     i_last_byte,
    output t_ctl_cmd o_cmd,
    output logic     o_busy
);

    t_state r_state;
    t_state n_state;
    logic   w_take;

    assign w_take = (r_state == S_IDLE) && i_start;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_mode) begin
                        n_state = S_READ;
                    end else if (i_last_byte) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands
    always_comb begin
        o_cmd.byte_step  = w_take && !i_mode;
        o_cmd.read_issue = w_take && i_mode;
        o_cmd.finish     = (r_state == S_FINISH);
        o_cmd.read_done  = (r_state == S_READ);
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- sv/pfl_datapath.sv -----
// datapath: both file parsers, palette memories, load decision and result registers
module pfl_datapath
    import pfl_pkg::*;
#(
    parameter int MAX_TRIPLE_ENTRIES = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_ctl_cmd               i_cmd,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_last_byte,
    input  logic [9:0]             i_read_index,
    output logic                   o_done,
    output logic [2:0]             o_status,
    output logic [COUNT_OUT_W-1:0] o_color_count,
    output logic [31:0]            o_entry_rgba,
    output logic                   o_entry_valid
);

    localparam int TAW = (MAX_TRIPLE_ENTRIES > 1) ? $clog2(MAX_TRIPLE_ENTRIES) : 1;
    localparam int CNT_RAW_W = $clog2(MAX_TRIPLE_ENTRIES + 1);
    localparam int CNT_W = (CNT_RAW_W > COUNT_OUT_W) ? CNT_RAW_W : COUNT_OUT_W;

    // file parse state
    logic [BYTE_CNT_W-1:0]   r_byte_total, n_byte_total;
    logic [2:0]              r_rec_phase, n_rec_phase;
    logic [1:0]              r_tri_phase, n_tri_phase;
    logic [7:0]              r_rec_idx, n_rec_idx;
    logic                    r_rec_mark, n_rec_mark;
    logic [15:0]             r_rec_col, n_rec_col;
    logic [15:0]             r_tri_col, n_tri_col;
    logic [7:0]              r_highest, n_highest;
    logic                    r_rec_ok, n_rec_ok;
    logic [TRIPLE_CNT_W-1:0] r_tri_cnt, n_tri_cnt;
    logic [255:0]            r_written, n_written;

    // loaded palette
    logic [1:0]              r_fmt, n_fmt;
    logic [CNT_W-1:0]        r_count, n_count;

    // read request
    logic                    r_rd_valid, n_rd_valid;
    logic                    r_rd_written, n_rd_written;

    // result registers
    logic                    r_done, n_done;
    logic [2:0]              r_status, n_status;
    logic [COUNT_OUT_W-1:0]  r_out_count, n_out_count;
    logic [31:0]             r_rgba, n_rgba;
    logic                    r_valid, n_valid;

    // memory signals
    logic                    w_rec_we;
    logic                    w_tri_we;
    logic [23:0]             w_rec_q;
    logic [23:0]             w_tri_q;
    logic                    w_pos0;
    logic                    w_below_limit;

    assign w_pos0        = (r_byte_total == '0);
    assign w_below_limit = (32'(r_byte_total) < SIZE_LIMIT);

    // memory write enables
    assign w_rec_we = i_cmd.byte_step && (r_rec_phase >= 3'd5) && r_rec_mark;
    assign w_tri_we = i_cmd.byte_step && (r_tri_phase >= 2'd2) && w_below_limit
                      && (32'(r_tri_cnt) < MAX_TRIPLE_ENTRIES);

    pfl_ram #(
        .WIDTH (24),
        .DEPTH (256)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (w_rec_we),
        .i_waddr (r_rec_idx),
        .i_wdata ({i_data_byte, r_rec_col}),
        .i_raddr (i_read_index[7:0]),
        .o_rdata (w_rec_q)
    );

    pfl_ram #(
        .WIDTH (24),
        .DEPTH (MAX_TRIPLE_ENTRIES)
    ) u_tri_ram (
        .i_clk   (i_clk),
        .i_we    (w_tri_we),
        .i_waddr (TAW'(r_tri_cnt)),
        .i_wdata ({i_data_byte, r_tri_col}),
        .i_raddr (TAW'(i_read_index)),
        .o_rdata (w_tri_q)
    );

    // next-state logic
    always_comb begin
        n_byte_total = r_byte_total;
        n_rec_phase  = r_rec_phase;
        n_tri_phase  = r_tri_phase;
        n_rec_idx    = r_rec_idx;
        n_rec_mark   = r_rec_mark;
        n_rec_col    = r_rec_col;
        n_tri_col    = r_tri_col;
        n_highest    = r_highest;
        n_rec_ok     = r_rec_ok;
        n_tri_cnt    = r_tri_cnt;
        n_written    = r_written;
        n_fmt        = r_fmt;
        n_count      = r_count;
        n_rd_valid   = r_rd_valid;
        n_rd_written = r_rd_written;
        n_done       = 1'b0;
        n_status     = r_status;
        n_out_count  = r_out_count;
        n_rgba       = r_rgba;
        n_valid      = r_valid;

        // one file byte through both parsers
        if (i_cmd.byte_step) begin
            if (w_pos0) begin
                n_fmt     = FMT_NONE;
                n_count   = '0;
                n_written = '0;
            end

            // six-byte record parse
            case (r_rec_phase)
                3'd0: begin
                    if (i_data_byte != REC_START) begin
                        n_rec_ok = 1'b0;
                    end
                end
                3'd1: n_rec_idx  = i_data_byte;
                3'd2: n_rec_mark = (i_data_byte == REC_SET);
                3'd3: n_rec_col  = {8'h00, i_data_byte};
                3'd4: n_rec_col  = {i_data_byte, r_rec_col[7:0]};
                default: begin
                    if (r_rec_mark) begin
                        n_written[r_rec_idx] = 1'b1;
                        if (r_rec_idx > r_highest) begin
                            n_highest = r_rec_idx;
                        end
                    end
                end
            endcase
            n_rec_phase = (r_rec_phase >= 3'd5) ? 3'd0 : r_rec_phase + 3'd1;

            // packed triple parse
            case (r_tri_phase)
                2'd0: n_tri_col = {8'h00, i_data_byte};
                2'd1: n_tri_col = {i_data_byte, r_tri_col[7:0]};
                default: begin
                    if (w_below_limit) begin
                        n_tri_cnt = r_tri_cnt + 1'b1;
                    end
                end
            endcase
            n_tri_phase = (r_tri_phase >= 2'd2) ? 2'd0 : r_tri_phase + 2'd1;

            // saturating byte count
            if (w_below_limit) begin
                n_byte_total = r_byte_total + 1'b1;
            end

            if (!i_last_byte) begin
                n_done      = 1'b1;
                n_status    = ST_BYTE;
                n_out_count = w_pos0 ? '0 : COUNT_OUT_W'(r_count);
                n_rgba      = '0;
                n_valid     = 1'b0;
            end
        end

        // load decision after the final byte
        if (i_cmd.finish) begin
            if ((r_byte_total < BYTE_CNT_W'(3)) || !w_below_limit) begin
                n_status = ST_BAD_SIZE;
            end else if (r_rec_ok && (r_rec_phase == 3'd0)) begin
                n_status = ST_ARCH;
                n_fmt    = FMT_ARCH;
                n_count  = CNT_W'(r_highest) + 1'b1;
            end else if (r_tri_phase != 2'd0) begin
                n_status = ST_BAD_FMT;
            end else if (32'(r_tri_cnt) > MAX_TRIPLE_ENTRIES) begin
                n_status = ST_BAD_SIZE;
            end else begin
                n_status = ST_RAW;
                n_fmt    = FMT_RAW;
                n_count  = CNT_W'(r_tri_cnt);
            end
            n_done       = 1'b1;
            n_out_count  = COUNT_OUT_W'(n_count);
            n_rgba       = '0;
            n_valid      = 1'b0;
            n_byte_total = '0;
            n_rec_phase  = '0;
            n_tri_phase  = '0;
            n_rec_idx    = '0;
            n_rec_mark   = 1'b0;
            n_rec_col    = '0;
            n_tri_col    = '0;
            n_highest    = '0;
            n_rec_ok     = 1'b1;
            n_tri_cnt    = '0;
        end

        // read request: range check, memory address goes out this cycle
        if (i_cmd.read_issue) begin
            n_rd_valid   = (CNT_W'(i_read_index) < r_count);
            n_rd_written = r_written[i_read_index[7:0]];
        end

        // read reply from registered memory data
        if (i_cmd.read_done) begin
            n_done      = 1'b1;
            n_status    = ST_READ;
            n_out_count = COUNT_OUT_W'(r_count);
            n_valid     = r_rd_valid;
            n_rgba      = '0;
            if (r_rd_valid) begin
                if (r_fmt == FMT_ARCH) begin
                    n_rgba = r_rd_written ? {ALPHA_FULL, w_rec_q} : '0;
                end else begin
                    n_rgba = {ALPHA_FULL, w_tri_q};
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_total <= '0;
            r_rec_phase  <= '0;
            r_tri_phase  <= '0;
            r_rec_idx    <= '0;
            r_rec_mark   <= 1'b0;
            r_rec_col    <= '0;
            r_tri_col    <= '0;
            r_highest    <= '0;
            r_rec_ok     <= 1'b1;
            r_tri_cnt    <= '0;
            r_written    <= '0;
            r_fmt        <= FMT_NONE;
            r_count      <= '0;
            r_done       <= 1'b0;
        end else begin
            r_byte_total <= n_byte_total;
            r_rec_phase  <= n_rec_phase;
            r_tri_phase  <= n_tri_phase;
            r_rec_idx    <= n_rec_idx;
            r_rec_mark   <= n_rec_mark;
            r_rec_col    <= n_rec_col;
            r_tri_col    <= n_tri_col;
            r_highest    <= n_highest;
            r_rec_ok     <= n_rec_ok;
            r_tri_cnt    <= n_tri_cnt;
            r_written    <= n_written;
            r_fmt        <= n_fmt;
            r_count      <= n_count;
            r_done       <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_valid   <= n_rd_valid;
        r_rd_written <= n_rd_written;
        r_status     <= n_status;
        r_out_count  <= n_out_count;
        r_rgba       <= n_rgba;
        r_valid      <= n_valid;
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_color_count = r_out_count;
    assign o_entry_rgba  = r_rgba;
    assign o_entry_valid = r_valid;

endmodule

// ----- sv/palette_file_loader_top.sv -----
// palette file loader: top level joining controller and datapath
//
// Feed the palette file one byte per request with mode 0 and flag the final
// byte with last_byte; issue mode 1 requests to read entries of the loaded
// palette. A request is taken when start is high and busy is low. Every
// request yields exactly one result, shown for a single cycle with o_done
// high; the receiver cannot stall it, so it must take each result as it
// appears. A file byte that is not the last leaves the controller idle, so
// the next request may follow at once. The final byte is parsed, then the
// finish state makes the load decision on the parser registers. A read
// answers from the registered read port of the palette memories. No clearing
// pass follows reset; the block accepts requests right away.
module palette_file_loader_top
    import pfl_pkg::*;
#(
    parameter int MAX_TRIPLE_ENTRIES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [9:0]  i_read_index,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [10:0] o_color_count,
    output logic [31:0] o_entry_rgba,
    output logic        o_entry_valid
);

    t_ctl_cmd w_cmd;

    // sequencing
    pfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_mode      (i_mode),
        .i_last_byte (i_last_byte),
        .o_cmd       (w_cmd),
        .o_busy      (busy)
    );

    // parsing, storage and results
    pfl_datapath #(
        .MAX_TRIPLE_ENTRIES (MAX_TRIPLE_ENTRIES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .i_read_index  (i_read_index),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_color_count (o_color_count),
        .o_entry_rgba  (o_entry_rgba),
        .o_entry_valid (o_entry_valid)
    );

endmodule

// ----- sv/pfl_checker.sv -----
// port-level checker for the palette file loader, bound to the top level
module pfl_checker
    import pfl_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_mode,
    input logic        i_last_byte,
    input logic        o_done,
    input logic [2:0]  o_status,
    input logic [10:0] o_color_count,
    input logic [31:0] o_entry_rgba,
    input logic        o_entry_valid
);

    // a non-final byte answers on the next cycle
    a_byte_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_mode && !i_last_byte) |=> (o_done && o_status == ST_BYTE))
        else $error("byte request without reply");

    // a read answers once the controller has passed its read state and the result is registered
    a_read_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode) |=> ##1 (o_done && o_status == ST_READ))
        else $error("read request without reply");

    // only read replies carry entry data
    a_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_READ) |-> (!o_entry_valid && o_entry_rgba == '0))
        else $error("entry data on a non-read result");

    // a failed load leaves the palette empty
    a_fail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_BAD_FMT || o_status == ST_BAD_SIZE))
            |-> (o_color_count == '0))
        else $error("failed load reports entries");

    // valid entries are opaque or unset
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_entry_valid) |-> (o_entry_rgba == '0 || o_entry_rgba[31:24] == ALPHA_FULL))
        else $error("valid entry with wrong alpha");

endmodule

bind palette_file_loader_top pfl_checker u_pfl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_mode        (i_mode),
    .i_last_byte   (i_last_byte),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_color_count (o_color_count),
    .o_entry_rgba  (o_entry_rgba),
    .o_entry_valid (o_entry_valid)
);
